>>> rtl/tlssni_pkg.sv
// ============================================================================
// TLS ClientHello SNI extractor - shared package
// Types and constants for the server-name parser: parse phases, result status
// codes, the parser state record and the per-byte result record.
// ============================================================================
package tlssni_pkg;

    // Record and handshake header values.
    localparam logic [7:0] CT_HANDSHAKE    = 8'h16;
    localparam logic [7:0] VER_MAJOR       = 8'h03;
    localparam logic [7:0] VER_MINOR_LO    = 8'h01;
    localparam logic [7:0] VER_MINOR_HI    = 8'h03;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0] NAME_TYPE_HOST  = 8'h00;

    // Header byte offsets.
    localparam logic [17:0] OFS_CONTENT_TYPE = 18'd0;
    localparam logic [17:0] OFS_VER_MAJOR    = 18'd1;
    localparam logic [17:0] OFS_VER_MINOR    = 18'd2;
    localparam logic [17:0] OFS_REC_LEN_HI   = 18'd3;
    localparam logic [17:0] OFS_REC_LEN_LO   = 18'd4;
    localparam logic [17:0] OFS_HS_TYPE      = 18'd5;
    localparam logic [17:0] OFS_HS_LEN_0     = 18'd6;
    localparam logic [17:0] OFS_HS_LEN_1     = 18'd7;

    // Record header, handshake header, client version and random.
    localparam int SID_OFFSET = 5 + 4 + 2 + 32;
    localparam int REC_HDR_LEN = 5;
    localparam int HS_HDR_LEN = 4;

    // Byte position saturates here on very long streams.
    localparam logic [17:0] POS_MAX = 18'h3FFFF;

    // Parse phases, one-hot.
    typedef enum logic [10:0] {
        PH_HDR     = 11'b000_0000_0001,
        PH_RANDOM  = 11'b000_0000_0010,
        PH_SID     = 11'b000_0000_0100,
        PH_CS      = 11'b000_0000_1000,
        PH_COMP    = 11'b000_0001_0000,
        PH_EXTLEN  = 11'b000_0010_0000,
        PH_EXTHDR  = 11'b000_0100_0000,
        PH_LISTLEN = 11'b000_1000_0000,
        PH_ENTRY   = 11'b001_0000_0000,
        PH_NAME    = 11'b010_0000_0000,
        PH_DONE    = 11'b100_0000_0000
    } phase_t;

    // Final status of a packet.
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_REJECT    = 2'd1,
        ST_NO_NAME   = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    // Parser state carried from byte to byte.
    typedef struct packed {
        phase_t      phase;
        logic [17:0] pos;
        logic [16:0] rec_end;
        logic [17:0] skip;
        logic [23:0] acc;
        logic [17:0] ext_end;
        logic [17:0] list_end;
        logic [15:0] name_rem;
        logic [15:0] rec_len;
    } state_t;

    // Result of one byte step.
    typedef struct packed {
        logic        valid;
        logic [7:0]  name_byte;
        logic        is_name;
        logic        done;
        status_t     status;
        logic [15:0] name_length;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:    PH_HDR,
        pos:      18'd0,
        rec_end:  17'd0,
        skip:     18'd0,
        acc:      24'd0,
        ext_end:  18'd0,
        list_end: 18'd0,
        name_rem: 16'd0,
        rec_len:  16'd0
    };

endpackage

>>> rtl/tlssni_pkt_if.sv
// ============================================================================
// TLS SNI extractor - packet byte channel
// Valid/ready channel carrying one captured packet byte and its end flag.
// ============================================================================
interface tlssni_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/tlssni_res_if.sv
// ============================================================================
// TLS SNI extractor - result channel
// Valid/ready channel carrying one hostname byte and/or the packet status.
// ============================================================================
interface tlssni_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  name_byte;
    logic        is_name_byte;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] name_length;

    modport source (output valid, output name_byte, output is_name_byte, output done_res,
                    output status, output name_length, input ready);
    modport sink   (input valid, input name_byte, input is_name_byte, input done_res,
                    input status, input name_length, output ready);
endinterface

>>> rtl/tlssni_step.sv
// ============================================================================
// TLS SNI extractor - byte step logic
// Combinational next-state and result logic for one packet byte: header
// checks, length-prefixed field skipping, extension and name-list walking,
// and hostname byte streaming.
// ============================================================================
module tlssni_step (
    input  tlssni_pkg::state_t  st,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output tlssni_pkg::state_t  nx,
    output tlssni_pkg::result_t res
);
    import tlssni_pkg::*;

    logic        fin;
    status_t     fin_st;
    logic [15:0] fin_len;
    logic        at_field;
    logic        first;
    logic [17:0] i_ofs;
    logic [23:0] acc_eff;
    logic [23:0] acc_sh;
    logic [23:0] hs_len;
    logic [18:0] p1;
    logic [18:0] sum_b;
    logic [18:0] sum_a;
    logic [18:0] rend;

    always_comb
    begin
        nx      = st;
        res     = '0;
        fin     = 1'b0;
        fin_st  = ST_FOUND;
        fin_len = 16'd0;
        hs_len  = {st.acc[15:0], data_byte};

        // Offset within the current field and the shared position sums.
        at_field = (st.pos >= st.skip);
        i_ofs    = st.pos - st.skip;
        first    = (i_ofs == 18'd0);
        acc_eff  = first ? 24'd0 : st.acc;
        acc_sh   = {acc_eff[15:0], data_byte};
        p1       = {1'b0, st.pos} + 19'd1;
        sum_b    = p1 + {11'd0, data_byte};
        sum_a    = p1 + {3'd0, acc_sh[15:0]};
        rend     = {2'd0, st.rec_end};

        unique case (st.phase)
            PH_HDR:
            begin
                // Fixed record and handshake header bytes.
                if (st.pos == OFS_CONTENT_TYPE)
                begin
                    if (data_byte != CT_HANDSHAKE)
                    begin
                        fin = 1'b1; fin_st = ST_REJECT;
                    end
                end
                else if (st.pos == OFS_VER_MAJOR)
                begin
                    if (data_byte != VER_MAJOR)
                    begin
                        fin = 1'b1; fin_st = ST_REJECT;
                    end
                end
                else if (st.pos == OFS_VER_MINOR)
                begin
                    if (data_byte < VER_MINOR_LO || data_byte > VER_MINOR_HI)
                    begin
                        fin = 1'b1; fin_st = ST_REJECT;
                    end
                end
                else if (st.pos == OFS_REC_LEN_HI)
                begin
                    nx.rec_len = {data_byte, 8'h00};
                end
                else if (st.pos == OFS_REC_LEN_LO)
                begin
                    nx.rec_len = {st.rec_len[15:8], data_byte};
                end
                else if (st.pos == OFS_HS_TYPE)
                begin
                    if (data_byte != HS_CLIENT_HELLO)
                    begin
                        fin = 1'b1; fin_st = ST_REJECT;
                    end
                end
                else if (st.pos == OFS_HS_LEN_0)
                begin
                    nx.acc = {16'd0, data_byte};
                end
                else if (st.pos == OFS_HS_LEN_1)
                begin
                    nx.acc = hs_len;
                end
                else
                begin
                    // Handshake must fit in the record.
                    nx.acc = hs_len;
                    if ({1'b0, hs_len} + 25'(HS_HDR_LEN) > {9'd0, st.rec_len})
                    begin
                        fin = 1'b1; fin_st = ST_REJECT;
                    end
                    else
                    begin
                        nx.rec_end = {1'b0, st.rec_len} + 17'(REC_HDR_LEN);
                        nx.phase   = PH_RANDOM;
                    end
                end
            end

            PH_RANDOM:
            begin
                // Wait out the version and random, then read the session id length.
                if (st.pos >= 18'(SID_OFFSET - 1))
                begin
                    if (19'(SID_OFFSET + 1) > rend)
                    begin
                        fin = 1'b1; fin_st = ST_NO_NAME;
                    end
                    else
                    begin
                        nx.skip  = 18'(SID_OFFSET);
                        nx.phase = PH_SID;
                    end
                end
            end

            PH_SID:
            begin
                if (at_field)
                begin
                    if (sum_b + 19'd2 > rend)
                    begin
                        fin = 1'b1; fin_st = ST_NO_NAME;
                    end
                    else
                    begin
                        nx.skip  = sum_b[17:0];
                        nx.phase = PH_CS;
                    end
                end
            end

            PH_CS:
            begin
                if (at_field)
                begin
                    nx.acc = acc_sh;
                    if (!first)
                    begin
                        if (sum_a + 19'd1 > rend)
                        begin
                            fin = 1'b1; fin_st = ST_NO_NAME;
                        end
                        else
                        begin
                            nx.skip  = sum_a[17:0];
                            nx.phase = PH_COMP;
                        end
                    end
                end
            end

            PH_COMP:
            begin
                if (at_field)
                begin
                    if (sum_b + 19'd2 > rend)
                    begin
                        fin = 1'b1; fin_st = ST_NO_NAME;
                    end
                    else
                    begin
                        nx.skip  = sum_b[17:0];
                        nx.phase = PH_EXTLEN;
                    end
                end
            end

            PH_EXTLEN:
            begin
                if (at_field)
                begin
                    nx.acc = acc_sh;
                    if (!first)
                    begin
                        nx.ext_end = sum_a[17:0];
                        if (p1 + 19'd4 <= sum_a && p1 + 19'd4 <= rend)
                        begin
                            nx.skip  = p1[17:0];
                            nx.phase = PH_EXTHDR;
                        end
                        else
                        begin
                            fin = 1'b1; fin_st = ST_NO_NAME;
                        end
                    end
                end
            end

            PH_EXTHDR:
            begin
                if (at_field)
                begin
                    if (i_ofs < 18'd2)
                    begin
                        // Any nonzero type byte marks a foreign extension.
                        nx.acc = acc_eff | ((data_byte != 8'h00) ? 24'h010000 : 24'h000000);
                    end
                    else
                    begin
                        nx.acc = {7'd0, acc_eff[16], acc_sh[15:0]};
                        if (i_ofs >= 18'd3)
                        begin
                            if (!acc_eff[16])
                            begin
                                // Server name extension: read the list length.
                                if (p1 + 19'd2 > rend)
                                begin
                                    fin = 1'b1; fin_st = ST_NO_NAME;
                                end
                                else
                                begin
                                    nx.skip  = p1[17:0];
                                    nx.phase = PH_LISTLEN;
                                end
                            end
                            else if (sum_a + 19'd4 <= {1'b0, st.ext_end} &&
                                     sum_a + 19'd4 <= rend)
                            begin
                                nx.skip  = sum_a[17:0];
                                nx.phase = PH_EXTHDR;
                            end
                            else
                            begin
                                fin = 1'b1; fin_st = ST_NO_NAME;
                            end
                        end
                    end
                end
            end

            PH_LISTLEN:
            begin
                if (at_field)
                begin
                    nx.acc = acc_sh;
                    if (!first)
                    begin
                        nx.list_end = sum_a[17:0];
                        if (p1 + 19'd3 <= sum_a && p1 + 19'd3 <= rend)
                        begin
                            nx.skip  = p1[17:0];
                            nx.phase = PH_ENTRY;
                        end
                        else
                        begin
                            fin = 1'b1; fin_st = ST_NO_NAME;
                        end
                    end
                end
            end

            PH_ENTRY:
            begin
                if (at_field)
                begin
                    nx.acc = acc_sh;
                    if (i_ofs >= 18'd2)
                    begin
                        if (acc_sh[23:16] == NAME_TYPE_HOST)
                        begin
                            if (sum_a > rend)
                            begin
                                fin = 1'b1; fin_st = ST_NO_NAME;
                            end
                            else if (acc_sh[15:0] == 16'd0)
                            begin
                                fin = 1'b1; fin_st = ST_FOUND;
                            end
                            else
                            begin
                                nx.acc      = {8'd0, acc_sh[15:0]};
                                nx.name_rem = acc_sh[15:0];
                                nx.skip     = p1[17:0];
                                nx.phase    = PH_NAME;
                            end
                        end
                        else if (sum_a + 19'd3 <= {1'b0, st.list_end} &&
                                 sum_a + 19'd3 <= rend)
                        begin
                            nx.skip  = sum_a[17:0];
                            nx.phase = PH_ENTRY;
                        end
                        else
                        begin
                            fin = 1'b1; fin_st = ST_NO_NAME;
                        end
                    end
                end
            end

            PH_NAME:
            begin
                // Stream the hostname; the last byte also carries the status.
                res.valid     = 1'b1;
                res.is_name   = 1'b1;
                res.name_byte = data_byte;
                nx.name_rem   = st.name_rem - 16'd1;
                if (nx.name_rem == 16'd0)
                begin
                    fin     = 1'b1;
                    fin_st  = ST_FOUND;
                    fin_len = st.acc[15:0];
                end
            end

            PH_DONE:
            begin
                // Decided: swallow bytes until the end of the packet.
            end

            default:
            begin
                fin = 1'b1; fin_st = ST_REJECT;
            end
        endcase

        if (fin)
        begin
            nx.phase = PH_DONE;
        end

        // End of the captured packet: close out and start over.
        if (last_byte)
        begin
            if (nx.phase != PH_DONE)
            begin
                fin     = 1'b1;
                fin_len = 16'd0;
                if (nx.phase == PH_NAME)
                begin
                    fin_st = ST_TRUNCATED;
                end
                else if (st.pos < 18'(SID_OFFSET - 1))
                begin
                    fin_st = ST_REJECT;
                end
                else
                begin
                    fin_st = ST_NO_NAME;
                end
            end
            nx = STATE_RESET;
        end
        else if (st.pos != POS_MAX)
        begin
            nx.pos = st.pos + 18'd1;
        end

        if (fin)
        begin
            res.valid       = 1'b1;
            res.done        = 1'b1;
            res.status      = fin_st;
            res.name_length = fin_len;
        end
    end

endmodule

>>> rtl/tls_client_hello_sni_extract.sv
// ============================================================================
// TLS ClientHello SNI extractor - top level
// Parses a captured TLS record byte by byte and streams out the first
// server_name host name, ending each packet with one status result.
// ============================================================================
// The block takes one packet byte per cycle and keeps that rate for as long
// as the result side keeps up; each byte goes through an input register,
// and its result through a result register. Each byte yields at most one
// result: a hostname byte, the packet's final status, or both on the last
// hostname byte. Ready drops only while the result register holds a result
// that the sink has not taken. After the final status of a packet, the
// remaining bytes up to the one flagged last_byte are consumed without
// results, and the byte after it starts a new packet at offset zero.
module tls_client_hello_sni_extract (
    input  logic         clk,
    input  logic         rst_n,
    tlssni_pkt_if.sink   pkt,
    tlssni_res_if.source sni
);
    import tlssni_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;
    state_t     st_reg;
    state_t     st_next;
    result_t    res_next;
    logic       out_valid_reg;
    result_t    out_res_reg;
    logic       out_free;
    logic       adv;

    // The step runs when the result register can take its output.
    assign out_free  = !out_valid_reg || sni.ready;
    assign adv       = s1_valid_reg && out_free;
    assign pkt.ready = !s1_valid_reg || out_free;

    tlssni_step u_step (
        .st        (st_reg),
        .data_byte (s1_data_reg),
        .last_byte (s1_last_reg),
        .nx        (st_next),
        .res       (res_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pkt.ready)
        begin
            s1_valid_reg <= pkt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            s1_data_reg <= pkt.data_byte;
            s1_last_reg <= pkt.last_byte;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= STATE_RESET;
        end
        else if (adv)
        begin
            st_reg <= st_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= adv && res_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res_next.valid)
        begin
            out_res_reg <= res_next;
        end
    end

    assign sni.valid        = out_valid_reg;
    assign sni.name_byte    = out_res_reg.name_byte;
    assign sni.is_name_byte = out_res_reg.is_name;
    assign sni.done_res     = out_res_reg.done;
    assign sni.status       = out_res_reg.status;
    assign sni.name_length  = out_res_reg.name_length;

    // A status result leaves the parser decided or at the start of a packet.
    a_done_settles: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res_next.done |=> (st_reg.phase == PH_DONE || st_reg.phase == PH_HDR))
        else $error("parser kept running after a final status");

    // Every result carries a hostname byte, a status, or both.
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.is_name |-> out_res_reg.done)
        else $error("empty result transfer");

    // Name length is reported only with a found status.
    a_len_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.status != ST_FOUND |-> out_res_reg.name_length == 16'd0)
        else $error("name length with a failing status");

    // The byte after a packet's last byte is parsed at offset zero.
    a_new_packet: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_last_reg |=> st_reg.pos == 18'd0 && st_reg.phase == PH_HDR)
        else $error("packet end did not restart the parser");

endmodule
